// ----- rtl/pfs_pkg.sv -----
// pfs_pkg: widths, search limits, controller states and command/status
// structs for the PLL factor search. No dependencies.
`default_nettype none

package pfs_pkg;

  // Payload widths
  localparam int CRYSTAL_W = 26;
  localparam int TARGET_W  = 29;
  localparam int PRE_W     = 6;
  localparam int MUL_W     = 9;
  localparam int POST_W    = 4;
  localparam int CORE_W    = 28;
  localparam int FW_W      = 3;

  // Internal widths
  localparam int VIN_W        = 21;  // VCO input, wide enough for values inside its window
  localparam int VOUT_W       = 30;  // VCO output, up to 2 MHz * 432
  localparam int DIVD_W       = 29;  // serial divider dividend / quotient
  localparam int DIVS_W       = 8;   // serial divider divisor (pre-divider)
  localparam int POST_IDX_W   = 2;
  localparam int RECIP_W      = 32;
  localparam int WAIT_RECIP_W = 30;

  // Search limits
  localparam logic [DIVD_W-1:0] VIN_MIN   = 29'd1_000_000;
  localparam logic [DIVD_W-1:0] VIN_MAX   = 29'd2_000_000;
  localparam logic [VOUT_W-1:0] VOUT_MIN  = 30'd64_000_000;
  localparam logic [VOUT_W-1:0] VOUT_MAX  = 30'd432_000_000;
  localparam logic [PRE_W-1:0]  PRE_FIRST = 6'd2;
  localparam logic [PRE_W-1:0]  PRE_LAST  = 6'd63;
  localparam logic [MUL_W-1:0]  MUL_FIRST = 9'd64;
  localparam logic [MUL_W-1:0]  MUL_LAST  = 9'd432;
  localparam logic [POST_IDX_W-1:0] POST_IDX_LAST = 2'd3;

  // floor(n/3) = (n * RECIP3) >> 33 for any n below 2^32
  localparam logic [RECIP_W-1:0] RECIP3      = 32'hAAAA_AAAB;
  localparam int                 RECIP_SHIFT = 33;

  // floor(n/30 MHz) = (n * WAIT_RECIP) >> 54 for any n below 2^29
  localparam logic [WAIT_RECIP_W-1:0] WAIT_RECIP = 30'd600_479_951;
  localparam int                      WAIT_SHIFT = 54;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FW,
    S_PRE_DIV,
    S_VIN_WAIT,
    S_PRE_CHK,
    S_MUL_CHK,
    S_POST,
    S_NEXT_MUL,
    S_NEXT_PRE,
    S_DONE
  } state_e;

  typedef struct packed {
    logic     load;
    logic     div_start;
    logic     save_fw;
    logic     load_vin;
    logic     calc6;
    logic     try_post;
    logic     step_mul;
    logic     step_pre;
    logic     publish;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_done;
    logic vin_ok;
    logic vout_ok;
    logic post_last;
    logic mul_last;
    logic pre_last;
  } sts_t;

  // Post-divider value for index 0..3: 2, 4, 6, 8
  function automatic logic [POST_W-1:0] post_of(input logic [POST_IDX_W-1:0] idx);
    logic [POST_W-2:0] n;
    n = {1'b0, idx} + 3'd1;
    return {n, 1'b0};
  endfunction

endpackage

`default_nettype wire

// ----- rtl/pfs_req_if.sv -----
// pfs_req_if: request channel (crystal and target frequency).
// Depends on pfs_pkg.
`default_nettype none

interface pfs_req_if import pfs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CRYSTAL_W-1:0] crystal_hz;
  logic [TARGET_W-1:0]  target_hz;

  modport source (output valid, crystal_hz, target_hz, input ready);
  modport sink   (input valid, crystal_hz, target_hz, output ready);
endinterface

`default_nettype wire

// ----- rtl/pfs_rsp_if.sv -----
// pfs_rsp_if: result channel (chosen PLL factors and flash wait states).
// Depends on pfs_pkg.
`default_nettype none

interface pfs_rsp_if import pfs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              found;
  logic [PRE_W-1:0]  pre_divider;
  logic [MUL_W-1:0]  multiplier;
  logic [POST_W-1:0] post_divider;
  logic [CORE_W-1:0] core_hz;
  logic [FW_W-1:0]   flash_wait;

  modport source (output valid, found, pre_divider, multiplier, post_divider, core_hz,
                  flash_wait, input ready);
  modport sink   (input valid, found, pre_divider, multiplier, post_divider, core_hz,
                  flash_wait, output ready);
endinterface

`default_nettype wire

// ----- rtl/pll_factor_search.sv -----
// pll_factor_search: top level of the PLL factor search.
// Depends on pfs_pkg, pfs_req_if, pfs_rsp_if, pfs_ctrl and pfs_datapath.
`default_nettype none

// For each request (crystal_hz, target_hz) the block walks every pre-divider
// 2..63, every multiplier 64..432 and every post-divider 2, 4, 6, 8 and
// returns the combination with the highest core frequency not above the
// target, with the VCO input held to 1..2 MHz and the VCO output to
// 64..432 MHz; the earliest combination wins a tie. found is 0 and all
// factors and core_hz are 0 when nothing fits. flash_wait is target/30 MHz,
// low three bits. One request is worked at a time. The search first does the
// flash-wait reciprocal multiply, then for each pre-divider the serial
// crystal/pre-divider division (one quotient bit a cycle over 29 bits) and
// its bookkeeping, plus, when its VCO input lies in the window, a step per
// multiplier and a try of each post-divider for every multiplier whose VCO
// output lies in its window. A new request is taken as soon as the previous
// search has handed its result to the output register; the result then
// waits there until the sink takes it.

module pll_factor_search import pfs_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  pfs_req_if.sink    req_i,
  pfs_rsp_if.source  rsp_o
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer: owns request ready and result valid
  pfs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Counters, VCO arithmetic, best-so-far and the result payload
  pfs_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .crystal_hz_i   (req_i.crystal_hz),
    .target_hz_i    (req_i.target_hz),
    .found_o        (rsp_o.found),
    .pre_divider_o  (rsp_o.pre_divider),
    .multiplier_o   (rsp_o.multiplier),
    .post_divider_o (rsp_o.post_divider),
    .core_hz_o      (rsp_o.core_hz),
    .flash_wait_o   (rsp_o.flash_wait)
  );

  // The serial divider is never restarted in the middle of a division
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |-> !sts.div_busy)
    else $error("divider started while busy");

  // A found result carries a legal post-divider, pre-divider and multiplier
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.found) |->
      ((rsp_o.post_divider == 4'd2 || rsp_o.post_divider == 4'd4 ||
        rsp_o.post_divider == 4'd6 || rsp_o.post_divider == 4'd8) &&
       rsp_o.pre_divider >= PRE_FIRST && rsp_o.multiplier >= MUL_FIRST))
    else $error("found result with illegal factors");

  // No result found means every factor and the core frequency are zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.found) |->
      (rsp_o.pre_divider == '0 && rsp_o.multiplier == '0 &&
       rsp_o.post_divider == '0 && rsp_o.core_hz == '0))
    else $error("empty result carries nonzero factors");

  // A request is only taken while no search command is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !sts.div_busy && !cmd.try_post)
    else $error("request accepted during a search");

endmodule

`default_nettype wire

// ----- rtl/pfs_divider.sv -----
// pfs_divider: restoring serial divider, one quotient bit per cycle.
// Depends on pfs_pkg.
`default_nettype none

module pfs_divider import pfs_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [DIVD_W-1:0] dividend_i,
  input  wire logic [DIVS_W-1:0] divisor_i,
  output logic                   busy_o,
  output logic                   done_o,
  output logic [DIVD_W-1:0]      quot_o
);

  localparam int CNT_W = $clog2(DIVD_W);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DIVS_W-1:0] rem_q, rem_d;
  logic [DIVS_W-1:0] dsr_q, dsr_d;
  logic [DIVD_W-1:0] quot_q, quot_d;

  logic [DIVS_W:0] trial;
  logic [DIVS_W:0] diff;
  logic            ge;

  assign trial = {rem_q, quot_q[DIVD_W-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign ge    = (trial >= {1'b0, dsr_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DIVD_W - 1);
      rem_d  = '0;
      dsr_d  = divisor_i;
      quot_d = dividend_i;
    end else if (busy_q) begin
      rem_d  = ge ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
      quot_d = {quot_q[DIVD_W-2:0], ge};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
    quot_q <= quot_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

// ----- rtl/pfs_datapath.sv -----
// pfs_datapath: search counters, VCO arithmetic, best-candidate registers
// and result payload. Depends on pfs_pkg and pfs_divider.
`default_nettype none

module pfs_datapath import pfs_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire cmd_t                 cmd_i,
  output sts_t                      sts_o,
  input  wire logic [CRYSTAL_W-1:0] crystal_hz_i,
  input  wire logic [TARGET_W-1:0]  target_hz_i,
  output logic                      found_o,
  output logic [PRE_W-1:0]          pre_divider_o,
  output logic [MUL_W-1:0]          multiplier_o,
  output logic [POST_W-1:0]         post_divider_o,
  output logic [CORE_W-1:0]         core_hz_o,
  output logic [FW_W-1:0]           flash_wait_o
);

  logic [CRYSTAL_W-1:0]  xtal_q;
  logic [TARGET_W-1:0]   target_q;
  logic [FW_W-1:0]       fw_q;
  logic [PRE_W-1:0]      pre_q;
  logic [MUL_W-1:0]      mul_q;
  logic [POST_IDX_W-1:0] pidx_q;
  logic [VIN_W-1:0]      vin_q;
  logic                  vin_ok_q;
  logic [VOUT_W-1:0]     vout_q;
  logic [CORE_W-1:0]     core6_q;
  logic [CORE_W-1:0]     best_core_q;
  logic [PRE_W-1:0]      best_pre_q;
  logic [MUL_W-1:0]      best_mul_q;
  logic [POST_W-1:0]     best_post_q;

  logic              found_q;
  logic [PRE_W-1:0]  pre_out_q;
  logic [MUL_W-1:0]  mul_out_q;
  logic [POST_W-1:0] post_out_q;
  logic [CORE_W-1:0] core_out_q;
  logic [FW_W-1:0]   fw_out_q;

  logic [DIVD_W-1:0] div_dividend;
  logic [DIVS_W-1:0] div_divisor;
  logic              div_busy;
  logic              div_done;
  logic [DIVD_W-1:0] div_quot;

  logic [DIVD_W-1:0]                half_vout;
  logic [DIVD_W+RECIP_W-1:0]        prod6;
  logic [TARGET_W+WAIT_RECIP_W-1:0] prod_fw;
  logic [CORE_W-1:0]                core_cand;
  logic                             vin_in_win;

  // The divider only ever computes crystal / pre-divider
  assign div_dividend = {{(DIVD_W-CRYSTAL_W){1'b0}}, xtal_q};
  assign div_divisor  = {{(DIVS_W-PRE_W){1'b0}}, pre_q};

  pfs_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign vin_in_win = (div_quot >= VIN_MIN) && (div_quot <= VIN_MAX);

  // target / 30 MHz by reciprocal
  assign prod_fw = target_q * WAIT_RECIP;

  // vout/6 = (vout/2)/3 by reciprocal; vout/2 stays below 2^32
  assign half_vout = vout_q[VOUT_W-1:1];
  assign prod6     = half_vout * RECIP3;

  // Valid VCO outputs stay below 2^29, so the dropped top bits are zero
  always_comb begin
    case (pidx_q)
      2'd0:    core_cand = vout_q[CORE_W:1];
      2'd1:    core_cand = vout_q[CORE_W+1:2];
      2'd2:    core_cand = core6_q;
      default: core_cand = {1'b0, vout_q[VOUT_W-1:3]};
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      xtal_q      <= crystal_hz_i;
      target_q    <= target_hz_i;
      pre_q       <= PRE_FIRST;
      best_core_q <= '0;
      best_pre_q  <= '0;
      best_mul_q  <= '0;
      best_post_q <= '0;
    end
    if (cmd_i.save_fw) begin
      fw_q <= prod_fw[WAIT_SHIFT+FW_W-1:WAIT_SHIFT];
    end
    if (cmd_i.load_vin) begin
      vin_q    <= div_quot[VIN_W-1:0];
      vin_ok_q <= vin_in_win;
      vout_q   <= {{(VOUT_W-VIN_W-6){1'b0}}, div_quot[VIN_W-1:0], 6'b0};
      mul_q    <= MUL_FIRST;
    end
    if (cmd_i.calc6) begin
      core6_q <= prod6[RECIP_SHIFT+CORE_W-1:RECIP_SHIFT];
      pidx_q  <= '0;
    end
    if (cmd_i.try_post) begin
      pidx_q <= pidx_q + 1'b1;
      if ({1'b0, core_cand} <= target_q && core_cand > best_core_q) begin
        best_core_q <= core_cand;
        best_pre_q  <= pre_q;
        best_mul_q  <= mul_q;
        best_post_q <= post_of(pidx_q);
      end
    end
    if (cmd_i.step_mul) begin
      mul_q  <= mul_q + 1'b1;
      vout_q <= vout_q + {{(VOUT_W-VIN_W){1'b0}}, vin_q};
    end
    if (cmd_i.step_pre) begin
      pre_q <= pre_q + 1'b1;
    end
    if (cmd_i.publish) begin
      found_q    <= (best_core_q != '0);
      pre_out_q  <= best_pre_q;
      mul_out_q  <= best_mul_q;
      post_out_q <= best_post_q;
      core_out_q <= best_core_q;
      fw_out_q   <= fw_q;
    end
  end

  assign sts_o.div_busy  = div_busy;
  assign sts_o.div_done  = div_done;
  assign sts_o.vin_ok    = vin_ok_q;
  assign sts_o.vout_ok   = (vout_q >= VOUT_MIN) && (vout_q <= VOUT_MAX);
  assign sts_o.post_last = (pidx_q == POST_IDX_LAST);
  assign sts_o.mul_last  = (mul_q == MUL_LAST);
  assign sts_o.pre_last  = (pre_q == PRE_LAST);

  assign found_o        = found_q;
  assign pre_divider_o  = pre_out_q;
  assign multiplier_o   = mul_out_q;
  assign post_divider_o = post_out_q;
  assign core_hz_o      = core_out_q;
  assign flash_wait_o   = fw_out_q;

endmodule

`default_nettype wire

// ----- rtl/pfs_ctrl.sv -----
// pfs_ctrl: sequencer for the factor search and the result valid flag.
// Depends on pfs_pkg.
`default_nettype none

module pfs_ctrl import pfs_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic req_valid_i,
  output logic      req_ready_o,
  output logic      rsp_valid_o,
  input  wire logic rsp_ready_i,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_FW;
        end
      end
      S_FW: begin
        cmd_o.save_fw = 1'b1;
        state_d       = S_PRE_DIV;
      end
      S_PRE_DIV: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_VIN_WAIT;
      end
      S_VIN_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.load_vin = 1'b1;
          state_d        = S_PRE_CHK;
        end
      end
      S_PRE_CHK: begin
        state_d = sts_i.vin_ok ? S_MUL_CHK : S_NEXT_PRE;
      end
      S_MUL_CHK: begin
        cmd_o.calc6 = 1'b1;
        state_d     = sts_i.vout_ok ? S_POST : S_NEXT_MUL;
      end
      S_POST: begin
        cmd_o.try_post = 1'b1;
        if (sts_i.post_last) begin
          state_d = S_NEXT_MUL;
        end
      end
      S_NEXT_MUL: begin
        if (sts_i.mul_last) begin
          state_d = S_NEXT_PRE;
        end else begin
          cmd_o.step_mul = 1'b1;
          state_d        = S_MUL_CHK;
        end
      end
      S_NEXT_PRE: begin
        if (sts_i.pre_last) begin
          state_d = S_DONE;
        end else begin
          cmd_o.step_pre = 1'b1;
          state_d        = S_PRE_DIV;
        end
      end
      S_DONE: begin
        if (!out_valid_q || rsp_ready_i) begin
          cmd_o.publish = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.publish) begin
      out_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign rsp_valid_o = out_valid_q;

endmodule

`default_nettype wire
